// ----- design/lbt_pkg.sv -----
// ============================================================================
// lbt_pkg
// Shared constants, controller/datapath interface types and constant
// dividers for the logarithmic brightness target block.
// ============================================================================
package lbt_pkg;

    localparam int LN2_MILLI      = 693;
    localparam int MANT_LIMIT     = 2000;
    localparam int MILLI          = 1000;
    // upper bound of y + t3/3 in the log series
    localparam int SERIES_MAX     = 345;
    localparam int POS_QW         = 10;
    localparam int DIV1000_RECIP  = 262;   // floor(2^18 / 1000)
    localparam int DIV3_RECIP     = 21;    // floor(2^6 / 3)

    localparam logic [1:0] LOG_DARK   = 2'd0;
    localparam logic [1:0] LOG_BRIGHT = 2'd1;
    localparam logic [1:0] LOG_SAMPLE = 2'd2;

    typedef struct packed {
        logic       capture;
        logic       load;
        logic       halve;
        logic       ydiv;
        logic       ysq;
        logic       d1;
        logic       mul2;
        logic       d2;
        logic       sum;
        logic       span;
        logic       pos_zero;
        logic       pos_sat;
        logic       pos_start;
        logic       pos_take;
        logic       scale;
        logic       finish;
        logic       push;
        logic [1:0] idx;
    } t_cmd;

    typedef struct packed {
        logic m_ge;
        logic div_busy;
        logic pos_zero;
        logic pos_ovf;
    } t_sts;

    // v / 1000 for v < 2^18: reciprocal estimate, then one correction
    function automatic logic [8:0] div1000(input logic [17:0] v);
        logic [26:0] prod;
        logic [8:0]  q0;
        logic [18:0] back;
        logic [18:0] rem;
        prod = 27'(v) * 27'(DIV1000_RECIP);
        q0   = prod[26:18];
        back = 19'(q0) * 19'(MILLI);
        rem  = {1'b0, v} - back;
        if (rem >= 19'(MILLI)) begin
            q0 = q0 + 9'd1;
        end
        return q0;
    endfunction

    // v / 3 for v < 48
    function automatic logic [3:0] div3(input logic [5:0] v);
        logic [10:0] prod;
        logic [4:0]  q0;
        logic [6:0]  back;
        logic [6:0]  rem;
        prod = 11'(v) * 11'(DIV3_RECIP);
        q0   = prod[10:6];
        back = 7'(q0) * 7'(3);
        rem  = 7'(v) - back;
        if (rem >= 7'(3)) begin
            q0 = q0 + 5'd1;
        end
        return 4'(q0);
    endfunction

endpackage

// ----- design/lbt_div.sv -----
// ============================================================================
// lbt_div
// Restoring divider, one quotient bit per cycle. The dividend must be
// below divisor * 2^Q_W.
// ============================================================================
module lbt_div #(
    parameter int DVS_W = 13,
    parameter int Q_W   = 10
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [DVS_W+Q_W-1:0]   i_dividend,
    input  logic [DVS_W-1:0]       i_divisor,
    output logic                   o_busy,
    output logic [Q_W-1:0]         o_quotient
);

    localparam int CNT_W = $clog2(Q_W + 1);

    logic [DVS_W-1:0] r_rem;
    logic [Q_W-1:0]   r_quo;
    logic [DVS_W-1:0] r_dvs;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;

    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   diff;
    logic             ge;

    assign trial = {r_rem, r_quo[Q_W-1]};
    assign diff  = trial - {1'b0, r_dvs};
    assign ge    = trial >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(Q_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend[DVS_W+Q_W-1:Q_W];
            r_quo <= i_dividend[Q_W-1:0];
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            r_quo <= {r_quo[Q_W-2:0], ge};
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;

endmodule

// ----- design/lbt_datapath.sv -----
// ============================================================================
// lbt_datapath
// Log approximation, position division, linear mapping, bias and clamp,
// and the output register.
// ============================================================================
module lbt_datapath import lbt_pkg::*; #(
    parameter int SENSOR_BITS = 12
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cmd                    i_cmd,
    output t_sts                    o_sts,
    input  logic [SENSOR_BITS-1:0]  i_light_sample,
    input  logic                    i_auto_mode,
    input  logic [7:0]              i_manual_brightness,
    input  logic signed [8:0]       i_brightness_bias,
    input  logic [11:0]             i_dark_count,
    input  logic [11:0]             i_bright_count,
    input  logic [7:0]              i_level_min,
    input  logic [7:0]              i_level_max,
    output logic [7:0]              o_brightness
);

    localparam int M_W   = SENSOR_BITS + 10;
    localparam int K_W   = $clog2(SENSOR_BITS + 1);
    localparam int LOG_W = $clog2(LN2_MILLI * SENSOR_BITS + 2 * SERIES_MAX + 1);
    localparam int NUM_W = LOG_W + POS_QW;

    logic [SENSOR_BITS-1:0] r_sample;
    logic [M_W-1:0]         r_m;
    logic [K_W-1:0]         r_k;
    logic [8:0]             r_y;
    logic [17:0]            r_p;
    logic [6:0]             r_a;
    logic [5:0]             r_t3;
    logic [LOG_W-1:0]       r_log_d;
    logic [LOG_W-1:0]       r_log_b;
    logic [LOG_W-1:0]       r_log_s;
    logic [NUM_W-1:0]       r_num;
    logic [LOG_W-1:0]       r_span;
    logic                   r_num_zero;
    logic                   r_neg_differ;
    logic [9:0]             r_pos;
    logic [17:0]            r_prod;
    logic                   r_prod_neg;
    logic [7:0]             r_res;
    logic [7:0]             r_brightness;

    logic [SENSOR_BITS-1:0] x_sel;
    logic [SENSOR_BITS-1:0] x_one;
    logic [10:0]            m_low;
    logic [9:0]             m_off;
    logic [19:0]            y_num;
    logic [11:0]            y_den;
    logic [NUM_W-1:0]       div_dividend;
    logic [LOG_W-1:0]       div_divisor;
    logic                   div_busy;
    logic [POS_QW-1:0]      div_q;
    logic [9:0]             series;
    logic [LOG_W-1:0]       log_val;
    logic signed [LOG_W:0]  diff_n;
    logic signed [LOG_W:0]  diff_s;
    logic [LOG_W-1:0]       num_mag;
    logic [LOG_W-1:0]       span_mag;
    logic signed [8:0]      hl;
    logic [7:0]             hl_mag;
    logic [8:0]             step;
    logic signed [10:0]     lo_s;
    logic signed [10:0]     hi_s;
    logic signed [10:0]     curve;
    logic signed [10:0]     tgt;

    always_comb begin
        case (i_cmd.idx)
            LOG_DARK:   x_sel = SENSOR_BITS'(i_dark_count);
            LOG_BRIGHT: x_sel = SENSOR_BITS'(i_bright_count);
            default:    x_sel = r_sample;
        endcase
    end

    assign x_one = (x_sel == '0) ? SENSOR_BITS'(1) : x_sel;

    // mantissa lies in [1000, 2000) once the halving loop ends
    assign m_low = r_m[10:0];
    assign m_off = 10'(m_low - 11'(MILLI));
    assign y_num = 20'(m_off) * 20'(MILLI);
    assign y_den = 12'(m_low) + 12'(MILLI);

    assign div_dividend = i_cmd.pos_start ? r_num  : NUM_W'(y_num);
    assign div_divisor  = i_cmd.pos_start ? r_span : LOG_W'(y_den);

    lbt_div #(
        .DVS_W (LOG_W),
        .Q_W   (POS_QW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.ydiv | i_cmd.pos_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_busy     (div_busy),
        .o_quotient (div_q)
    );

    // fifth-order term stays below 5 and truncates to zero
    assign series  = 10'(r_y) + 10'(div3(r_t3));
    assign log_val = LOG_W'(r_k) * LOG_W'(LN2_MILLI) + LOG_W'({series, 1'b0});

    assign diff_n   = $signed({1'b0, r_log_d}) - $signed({1'b0, r_log_s});
    assign diff_s   = $signed({1'b0, r_log_d}) - $signed({1'b0, r_log_b});
    assign num_mag  = diff_n[LOG_W] ? LOG_W'(-diff_n) : diff_n[LOG_W-1:0];
    assign span_mag = diff_s[LOG_W] ? LOG_W'(-diff_s) : diff_s[LOG_W-1:0];

    assign hl     = $signed({1'b0, i_level_max}) - $signed({1'b0, i_level_min});
    assign hl_mag = hl[8] ? 8'(-hl) : hl[7:0];

    assign step  = div1000(r_prod);
    assign lo_s  = $signed({3'b000, i_level_min});
    assign hi_s  = $signed({3'b000, i_level_max});
    assign curve = r_prod_neg ? (lo_s - $signed({2'b00, step}))
                              : (lo_s + $signed({2'b00, step}));

    always_comb begin
        if (i_auto_mode) begin
            tgt = curve + 11'(i_brightness_bias);
        end else begin
            tgt = $signed({3'b000, i_manual_brightness});
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_sample <= i_light_sample;
        end
        if (i_cmd.load) begin
            r_m <= M_W'(x_one) * M_W'(MILLI);
            r_k <= '0;
        end else if (i_cmd.halve) begin
            r_m <= r_m >> 1;
            r_k <= r_k + K_W'(1);
        end
        if (i_cmd.ysq) begin
            r_y <= div_q[8:0];
            r_p <= 18'(div_q[8:0]) * 18'(div_q[8:0]);
        end else if (i_cmd.mul2) begin
            r_p <= 18'(r_a) * 18'(r_y);
        end
        if (i_cmd.d1) begin
            r_a <= 7'(div1000(r_p));
        end
        if (i_cmd.d2) begin
            r_t3 <= 6'(div1000(r_p));
        end
        if (i_cmd.sum) begin
            case (i_cmd.idx)
                LOG_DARK:   r_log_d <= log_val;
                LOG_BRIGHT: r_log_b <= log_val;
                default:    r_log_s <= log_val;
            endcase
        end
        if (i_cmd.span) begin
            r_num        <= NUM_W'(num_mag) * NUM_W'(MILLI);
            r_span       <= span_mag;
            r_num_zero   <= (num_mag == '0);
            r_neg_differ <= diff_n[LOG_W] ^ diff_s[LOG_W];
        end
        if (i_cmd.pos_zero) begin
            r_pos <= '0;
        end else if (i_cmd.pos_sat) begin
            r_pos <= 10'(MILLI);
        end else if (i_cmd.pos_take) begin
            r_pos <= (div_q > 10'(MILLI)) ? 10'(MILLI) : div_q;
        end
        if (i_cmd.scale) begin
            r_prod     <= 18'(hl_mag) * 18'(r_pos);
            r_prod_neg <= hl[8];
        end
        if (i_cmd.finish) begin
            if (tgt < lo_s) begin
                r_res <= i_level_min;
            end else if (tgt > hi_s) begin
                r_res <= i_level_max;
            end else begin
                r_res <= tgt[7:0];
            end
        end
        if (i_cmd.push) begin
            r_brightness <= r_res;
        end
    end

    assign o_sts.m_ge     = r_m >= M_W'(MANT_LIMIT);
    assign o_sts.div_busy = div_busy;
    assign o_sts.pos_zero = (r_span == '0) | r_num_zero | r_neg_differ;
    assign o_sts.pos_ovf  = r_num >= {r_span, POS_QW'(0)};

    assign o_brightness = r_brightness;

endmodule

// ----- design/lbt_ctrl.sv -----
// ============================================================================
// lbt_ctrl
// Sequencer for the brightness datapath: in auto mode three log evaluations,
// position division and mapping; then the clamp and the output handshake.
// ============================================================================
module lbt_ctrl import lbt_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  logic i_auto_mode,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_LOAD  = 4'd1;
    localparam logic [3:0] S_HALVE = 4'd2;
    localparam logic [3:0] S_YWAIT = 4'd3;
    localparam logic [3:0] S_D1    = 4'd4;
    localparam logic [3:0] S_MUL2  = 4'd5;
    localparam logic [3:0] S_D2    = 4'd6;
    localparam logic [3:0] S_SUM   = 4'd7;
    localparam logic [3:0] S_SPAN  = 4'd8;
    localparam logic [3:0] S_POS   = 4'd9;
    localparam logic [3:0] S_PWAIT = 4'd10;
    localparam logic [3:0] S_SCALE = 4'd11;
    localparam logic [3:0] S_FINAL = 4'd12;
    localparam logic [3:0] S_DONE  = 4'd13;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic [1:0] r_idx;
    logic [1:0] n_idx;
    logic       r_out_valid;
    logic       n_out_valid;

    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        o_cmd     = '0;
        o_cmd.idx = r_idx;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_idx         = LOG_DARK;
                    n_state       = i_auto_mode ? S_LOAD : S_FINAL;
                end
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                n_state    = S_HALVE;
            end
            S_HALVE: begin
                if (i_sts.m_ge) begin
                    o_cmd.halve = 1'b1;
                end else begin
                    o_cmd.ydiv = 1'b1;
                    n_state    = S_YWAIT;
                end
            end
            S_YWAIT: begin
                if (!i_sts.div_busy) begin
                    o_cmd.ysq = 1'b1;
                    n_state   = S_D1;
                end
            end
            S_D1: begin
                o_cmd.d1 = 1'b1;
                n_state  = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.mul2 = 1'b1;
                n_state    = S_D2;
            end
            S_D2: begin
                o_cmd.d2 = 1'b1;
                n_state  = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                if (r_idx == LOG_SAMPLE) begin
                    n_state = S_SPAN;
                end else begin
                    n_idx   = r_idx + 2'd1;
                    n_state = S_LOAD;
                end
            end
            S_SPAN: begin
                o_cmd.span = 1'b1;
                n_state    = S_POS;
            end
            S_POS: begin
                if (i_sts.pos_zero) begin
                    o_cmd.pos_zero = 1'b1;
                    n_state        = S_SCALE;
                end else if (i_sts.pos_ovf) begin
                    o_cmd.pos_sat = 1'b1;
                    n_state       = S_SCALE;
                end else begin
                    o_cmd.pos_start = 1'b1;
                    n_state         = S_PWAIT;
                end
            end
            S_PWAIT: begin
                if (!i_sts.div_busy) begin
                    o_cmd.pos_take = 1'b1;
                    n_state        = S_SCALE;
                end
            end
            S_SCALE: begin
                o_cmd.scale = 1'b1;
                n_state     = S_FINAL;
            end
            S_FINAL: begin
                o_cmd.finish = 1'b1;
                n_state      = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (o_cmd.push) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= LOG_DARK;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ----- design/log_ambient_brightness_target.sv -----
// ============================================================================
// log_ambient_brightness_target
// Maps one light-sensor sample to a display brightness. In auto mode the
// sample's position between the dark and bright counts on a milli-scaled
// natural-log scale is mapped linearly onto level_min..level_max, the bias
// is added and the result clamped; in manual mode manual_brightness is
// clamped. One item is processed at a time. Manual mode skips the log
// evaluations. In auto mode each of the three logs halves its mantissa k
// times (k from 0 to SENSOR_BITS-1, one halving per cycle) and then waits
// on the shared one-bit-per-cycle divider, which the position division
// reuses. Either mode can also wait on the output. A finished result
// waits in an output register while the next item is accepted.
// ============================================================================
module log_ambient_brightness_target import lbt_pkg::*; #(
    parameter int SENSOR_BITS = 12
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [SENSOR_BITS-1:0]  i_light_sample,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [7:0]              o_brightness,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [4:0]              paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    localparam logic [2:0] REG_AUTO   = 3'd0;
    localparam logic [2:0] REG_MANUAL = 3'd1;
    localparam logic [2:0] REG_BIAS   = 3'd2;
    localparam logic [2:0] REG_DARK   = 3'd3;
    localparam logic [2:0] REG_BRIGHT = 3'd4;
    localparam logic [2:0] REG_MIN    = 3'd5;
    localparam logic [2:0] REG_MAX    = 3'd6;

    logic              r_auto_mode;
    logic [7:0]        r_manual_brightness;
    logic signed [8:0] r_brightness_bias;
    logic [11:0]       r_dark_count;
    logic [11:0]       r_bright_count;
    logic [7:0]        r_level_min;
    logic [7:0]        r_level_max;

    logic              wr_en;
    logic [2:0]        reg_idx;
    t_cmd              w_cmd;
    t_sts              w_sts;

    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[4:2];
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_auto_mode         <= 1'b1;
            r_manual_brightness <= 8'd128;
            r_brightness_bias   <= '0;
            r_dark_count        <= 12'd50;
            r_bright_count      <= 12'd3000;
            r_level_min         <= 8'd2;
            r_level_max         <= 8'd255;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_AUTO:   r_auto_mode         <= pwdata[0];
                REG_MANUAL: r_manual_brightness <= pwdata[7:0];
                REG_BIAS:   r_brightness_bias   <= $signed(pwdata[8:0]);
                REG_DARK:   r_dark_count        <= pwdata[11:0];
                REG_BRIGHT: r_bright_count      <= pwdata[11:0];
                REG_MIN:    r_level_min         <= pwdata[7:0];
                REG_MAX:    r_level_max         <= pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_AUTO:   prdata = {31'd0, r_auto_mode};
            REG_MANUAL: prdata = {24'd0, r_manual_brightness};
            REG_BIAS:   prdata = {23'd0, r_brightness_bias};
            REG_DARK:   prdata = {20'd0, r_dark_count};
            REG_BRIGHT: prdata = {20'd0, r_bright_count};
            REG_MIN:    prdata = {24'd0, r_level_min};
            REG_MAX:    prdata = {24'd0, r_level_max};
            default:    prdata = '0;
        endcase
    end

    lbt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_auto_mode (r_auto_mode),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    lbt_datapath #(
        .SENSOR_BITS (SENSOR_BITS)
    ) u_datapath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (w_cmd),
        .o_sts               (w_sts),
        .i_light_sample      (i_light_sample),
        .i_auto_mode         (r_auto_mode),
        .i_manual_brightness (r_manual_brightness),
        .i_brightness_bias   (r_brightness_bias),
        .i_dark_count        (r_dark_count),
        .i_bright_count      (r_bright_count),
        .i_level_min         (r_level_min),
        .i_level_max         (r_level_max),
        .o_brightness        (o_brightness)
    );

`ifndef ASSERT_OFF
    a_no_div_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.ydiv || w_cmd.pos_start) |-> !w_sts.div_busy)
        else $error("divider started while busy");

    a_no_result_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.push |-> (!o_out_valid || i_out_ready))
        else $error("pending result overwritten");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second item accepted while first in flight");

    a_result_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (r_level_min <= r_level_max)) |->
        ((o_brightness >= r_level_min) && (o_brightness <= r_level_max)))
        else $error("brightness outside level range");
`endif

endmodule

// ----- tb/log_ambient_brightness_target_tb.sv -----
`timescale 1ns / 1ps
// ============================================================================
// log_ambient_brightness_target_tb
// Self-checking bench for the log brightness target. Light samples go in
// over a valid/ready channel, and a local fixed-point model works out the
// brightness for each one. The APB registers are exercised by writes and
// readback. Directed checks cover the field extremes, manual mode, zero
// span, downward curves, bias extremes and a write to an unused register.
// They are followed by random items under varying configs and idle ratios.
// ============================================================================
module log_ambient_brightness_target_tb import lbt_pkg::*; ();

    localparam int CYCLE_LIMIT    = 1_000_000;
    localparam int BLOCK_ITEMS    = 50;
    localparam int RANDOM_ITEMS   = 1950;
    localparam int TAIL_CYCLES    = 120;
    localparam int SHOWN_ERRORS   = 10;

    typedef enum int {
        REG_AUTO_MODE,
        REG_MANUAL,
        REG_BIAS,
        REG_DARK,
        REG_BRIGHT,
        REG_LEVEL_MIN,
        REG_LEVEL_MAX,
        REG_SPARE
    } t_reg_idx;

    localparam int REG_BITS [0:7] = '{1, 8, 9, 12, 12, 8, 8, 32};

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [11:0] i_light_sample;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [7:0]  o_brightness;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // shadow of the register file
    logic        cfg_auto;
    logic [7:0]  cfg_manual;
    logic [8:0]  cfg_bias;
    logic [11:0] cfg_dark;
    logic [11:0] cfg_bright;
    logic [7:0]  cfg_min;
    logic [7:0]  cfg_max;

    logic [7:0]  brightness_due[$];
    logic [7:0]  due_value;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          cycle_count;
    int          error_count;
    int          items_sent;
    int          auto_items;
    int          results_seen;
    int          reg_writes;

    log_ambient_brightness_target dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_light_sample (i_light_sample),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_brightness   (o_brightness),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_count, brightness_due.size());
            $display("log_ambient_brightness_target_tb: errors");
            $finish;
        end
    end

    // milli-scaled natural log, series form
    function automatic longint milli_log(longint x);
        longint k, m, y, t, s;
        k = 0;
        if (x < 1) begin
            x = 1;
        end
        m = x * MILLI;
        while (m >= MANT_LIMIT) begin
            m = m / 2;
            k = k + 1;
        end
        y = (m - MILLI) * MILLI / (m + MILLI);
        s = y;
        t = y * y / MILLI * y / MILLI;
        s = s + t / 3;
        t = t * y / MILLI * y / MILLI;
        s = s + t / 5;
        return k * LN2_MILLI + 2 * s;
    endfunction

    function automatic logic [7:0] predict_brightness(logic [11:0] sample);
        longint lo, hi, ld, lb, span, pos, target;
        lo = longint'(cfg_min);
        hi = longint'(cfg_max);
        if (cfg_auto) begin
            ld   = milli_log(longint'(cfg_dark));
            lb   = milli_log(longint'(cfg_bright));
            span = ld - lb;
            pos  = 0;
            if (span != 0) begin
                pos = (ld - milli_log(longint'(sample))) * MILLI / span;
            end
            if (pos < 0) begin
                pos = 0;
            end else if (pos > MILLI) begin
                pos = MILLI;
            end
            target = lo + (hi - lo) * pos / MILLI + longint'($signed(cfg_bias));
        end else begin
            target = longint'(cfg_manual);
        end
        if (target < lo) begin
            target = lo;
        end else if (target > hi) begin
            target = hi;
        end
        return target[7:0];
    endfunction

    function automatic logic [31:0] reg_mask(t_reg_idx idx);
        return 32'((64'd1 << REG_BITS[idx]) - 64'd1);
    endfunction

    function automatic logic [31:0] shadow_of(t_reg_idx idx);
        case (idx)
            REG_AUTO_MODE: return 32'(cfg_auto);
            REG_MANUAL:    return 32'(cfg_manual);
            REG_BIAS:      return 32'(cfg_bias);
            REG_DARK:      return 32'(cfg_dark);
            REG_BRIGHT:    return 32'(cfg_bright);
            REG_LEVEL_MIN: return 32'(cfg_min);
            REG_LEVEL_MAX: return 32'(cfg_max);
            default:       return 32'd0;
        endcase
    endfunction

    function automatic int pick_value(int lo_v, int hi_v);
        case ($urandom_range(0, 5))
            0:       return lo_v;
            1:       return hi_v;
            default: return int'($urandom_range(lo_v, hi_v));
        endcase
    endfunction

    function automatic logic [11:0] pick_sample();
        int v;
        case ($urandom_range(0, 6))
            0:       v = $urandom_range(0, 15);
            1:       v = int'(cfg_dark) + $urandom_range(0, 16) - 8;
            2:       v = int'(cfg_bright) + $urandom_range(0, 16) - 8;
            3:       v = (1 << $urandom_range(0, 11)) + $urandom_range(0, 2) - 1;
            default: v = $urandom_range(0, 4095);
        endcase
        if (v < 0) begin
            v = 0;
        end else if (v > 4095) begin
            v = 4095;
        end
        return 12'(v);
    endfunction

    task automatic report_error(string msg);
        error_count++;
        if (error_count <= SHOWN_ERRORS) begin
            $display("ERROR @%0t: %s", $realtime, msg);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (brightness_due.size() == 0) begin
                report_error($sformatf("unexpected item, brightness %0d", o_brightness));
            end else begin
                due_value = brightness_due.pop_front();
                if (o_brightness !== due_value) begin
                    report_error($sformatf("brightness expected %0d got %0d",
                                           due_value, o_brightness));
                end
            end
        end
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    task automatic write_reg(t_reg_idx idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 5'(4 * idx);
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_AUTO_MODE: cfg_auto   = value[0];
            REG_MANUAL:    cfg_manual = value[7:0];
            REG_BIAS:      cfg_bias   = value[8:0];
            REG_DARK:      cfg_dark   = value[11:0];
            REG_BRIGHT:    cfg_bright = value[11:0];
            REG_LEVEL_MIN: cfg_min    = value[7:0];
            REG_LEVEL_MAX: cfg_max    = value[7:0];
            default: ;
        endcase
        reg_writes++;
        @(posedge i_clk);
    endtask

    task automatic read_reg(t_reg_idx idx, output logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= 5'(4 * idx);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_sample(logic [11:0] sample);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        i_in_valid     <= 1'b1;
        i_light_sample <= sample;
        do @(posedge i_clk); while (!o_in_ready);
        brightness_due.push_back(predict_brightness(sample));
        items_sent++;
        if (cfg_auto) begin
            auto_items++;
        end
    endtask

    // wait for the block to go idle before touching registers
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (brightness_due.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic set_curve(logic [11:0] dark, logic [11:0] bright,
                             logic [7:0] lo, logic [7:0] hi, logic [8:0] bias);
        write_reg(REG_DARK, 32'(dark));
        write_reg(REG_BRIGHT, 32'(bright));
        write_reg(REG_LEVEL_MIN, 32'(lo));
        write_reg(REG_LEVEL_MAX, 32'(hi));
        write_reg(REG_BIAS, 32'(bias));
    endtask

    task automatic test_reset_defaults();
        send_sample(12'd0);
        send_sample(12'd1);
        send_sample(12'd50);
        send_sample(12'd3000);
        send_sample(12'd2048);
        send_sample(12'd4095);
        drain();
    endtask

    task automatic test_register_access();
        logic [31:0] data;
        for (int i = 0; i < 7; i++) begin
            write_reg(t_reg_idx'(i), $urandom());
            read_reg(t_reg_idx'(i), data);
            if ((data & reg_mask(t_reg_idx'(i))) !== shadow_of(t_reg_idx'(i))) begin
                report_error($sformatf("reg %0d read expected %0h got %0h", i,
                                       shadow_of(t_reg_idx'(i)), data));
            end
        end
        // unused index must leave every register alone
        write_reg(REG_SPARE, 32'hFFFF_FFFF);
        for (int i = 0; i < 7; i++) begin
            read_reg(t_reg_idx'(i), data);
            if ((data & reg_mask(t_reg_idx'(i))) !== shadow_of(t_reg_idx'(i))) begin
                report_error($sformatf("reg %0d changed by unused write, got %0h",
                                       i, data));
            end
        end
    endtask

    task automatic test_manual_mode();
        write_reg(REG_AUTO_MODE, 32'd0);
        write_reg(REG_MANUAL, 32'd200);
        set_curve(12'd50, 12'd3000, 8'd0, 8'd255, 9'h0FF);
        send_sample(12'd4095);
        drain();
        write_reg(REG_MANUAL, 32'd255);
        write_reg(REG_LEVEL_MIN, 32'd10);
        write_reg(REG_LEVEL_MAX, 32'd100);
        send_sample(12'd0);
        drain();
        write_reg(REG_MANUAL, 32'd0);
        send_sample(12'hAAA);
        drain();
        write_reg(REG_AUTO_MODE, 32'd1);
    endtask

    task automatic test_curve_corners();
        // zero log span
        set_curve(12'd700, 12'd700, 8'd0, 8'd255, 9'd0);
        send_sample(12'd10);
        send_sample(12'd4000);
        drain();
        // zero counts are taken as one
        set_curve(12'd0, 12'd4095, 8'd0, 8'd255, 9'd0);
        send_sample(12'd0);
        send_sample(12'h555);
        drain();
        // downward curve
        set_curve(12'd50, 12'd3000, 8'd200, 8'd20, 9'd0);
        send_sample(12'd0);
        send_sample(12'd4095);
        send_sample(12'd500);
        drain();
        // bias extremes
        set_curve(12'd50, 12'd3000, 8'd0, 8'd255, 9'h100);
        send_sample(12'd4095);
        drain();
        write_reg(REG_BIAS, 32'h0FF);
        send_sample(12'd60);
        drain();
        // position saturation and reversed counts
        set_curve(12'd100, 12'd1000, 8'd5, 8'd250, 9'd0);
        send_sample(12'd10);
        send_sample(12'd4000);
        drain();
        set_curve(12'd3000, 12'd50, 8'd0, 8'd255, 9'd0);
        send_sample(12'd300);
        drain();
    endtask

    task automatic randomize_config();
        int dark_v, bright_v, lo_v, hi_v, tmp;
        logic [8:0] bias_v;
        dark_v   = pick_value(0, 4095);
        bright_v = ($urandom_range(0, 9) == 0) ? dark_v : pick_value(0, 4095);
        lo_v     = pick_value(0, 255);
        hi_v     = pick_value(0, 255);
        if (lo_v > hi_v && $urandom_range(0, 4) != 0) begin
            tmp  = lo_v;
            lo_v = hi_v;
            hi_v = tmp;
        end
        case ($urandom_range(0, 4))
            0:       bias_v = 9'h100;
            1:       bias_v = 9'h0FF;
            2:       bias_v = 9'd0;
            default: bias_v = 9'($urandom_range(0, 511));
        endcase
        write_reg(REG_AUTO_MODE, ($urandom() << 1) | 32'($urandom_range(0, 7) != 0));
        write_reg(REG_MANUAL, ($urandom() << 8) | 32'(pick_value(0, 255)));
        write_reg(REG_BIAS, ($urandom() << 9) | 32'(bias_v));
        write_reg(REG_DARK, ($urandom() << 12) | 32'(dark_v));
        write_reg(REG_BRIGHT, ($urandom() << 12) | 32'(bright_v));
        write_reg(REG_LEVEL_MIN, ($urandom() << 8) | 32'(lo_v));
        write_reg(REG_LEVEL_MAX, ($urandom() << 8) | 32'(hi_v));
    endtask

    task automatic test_random_traffic();
        int per_phase;
        per_phase = RANDOM_ITEMS / 3;
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin send_idle_pct = 34; recv_idle_pct = 74; end
                1: begin send_idle_pct = 74; recv_idle_pct = 34; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            for (int n = 0; n < per_phase; n++) begin
                if (n % BLOCK_ITEMS == 0) begin
                    drain();
                    randomize_config();
                end
                send_sample(pick_sample());
            end
            drain();
        end
    endtask

    initial begin
        i_rst_n        <= 1'b0;
        i_in_valid     <= 1'b0;
        i_light_sample <= '0;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= '0;
        pwdata         <= '0;
        error_count    = 0;
        items_sent     = 0;
        auto_items     = 0;
        results_seen   = 0;
        reg_writes     = 0;
        send_idle_pct  = 34;
        recv_idle_pct  = 74;
        cfg_auto       = 1'b1;
        cfg_manual     = 8'd128;
        cfg_bias       = 9'd0;
        cfg_dark       = 12'd50;
        cfg_bright     = 12'd3000;
        cfg_min        = 8'd2;
        cfg_max        = 8'd255;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_register_access();
        test_manual_mode();
        test_curve_corners();
        test_random_traffic();

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("sent %0d samples (%0d in auto mode), checked %0d brightness values",
                 items_sent, auto_items, results_seen);
        $display("%0d register writes over %0d cycles, %0d mismatches",
                 reg_writes, cycle_count, error_count);
        if (error_count == 0 && brightness_due.size() == 0) begin
            $display("log_ambient_brightness_target_tb: clean");
        end else begin
            $display("log_ambient_brightness_target_tb: errors");
        end
        $finish;
    end

endmodule

// ----- files.f -----
design/lbt_pkg.sv
design/lbt_div.sv
design/lbt_datapath.sv
design/lbt_ctrl.sv
design/log_ambient_brightness_target.sv
tb/log_ambient_brightness_target_tb.sv
